[hw/rtl/cacr_pkg.sv]
// cacr_pkg: shared types and fixed constants of the conv2d channel accumulate core
// no dependencies; used by the window, accum and top level rtl files and the checker through scoped names
package cacr_pkg;

	// command codes of an input item
	localparam logic CMD_WEIGHT = 1'b0;
	localparam logic CMD_PIXEL  = 1'b1;

	// configuration register indexes
	localparam int  CFG_IDX_BITS  = 1;
	localparam int  CFG_DATA_BITS = 7;
	localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_SIZE = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_SIZE    = 1'b1;

	// raw register field widths
	localparam int KSIZE_BITS = 3;
	localparam int OSIZE_BITS = 7;

	// kernel coordinate field width of a weight load
	localparam int WPOS_BITS = 3;

	// result pixel range
	localparam int OUT_VALUE_BITS = 15;
	localparam logic [OUT_VALUE_BITS-1:0] OUT_VALUE_MAX = '1;

	// control flags that travel with an item down the pipeline
	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} ctl_t;

endpackage

[hw/rtl/cacr_ram.sv]
// cacr_ram: generic single write port, single read port ram with registered read
// no dependencies
module cacr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/cacr_window.sv]
// cacr_window: input stage, line buffer ram, kernel window, weights and products
// depends on cacr_pkg and cacr_ram
module cacr_window #(
	parameter int MAX_OUT_SIZE = 64,
	parameter int MAX_KERNEL   = 5,
	parameter int PIXEL_BITS   = 16,
	localparam int ROW_LEN = MAX_OUT_SIZE + MAX_KERNEL - 1,
	localparam int LINES   = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1,
	localparam int PW      = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1,
	localparam int SW      = (LINES > 1) ? $clog2(LINES) : 1,
	localparam int KW      = $clog2(MAX_KERNEL + 1),
	localparam int OSW     = $clog2(MAX_OUT_SIZE + 1),
	localparam int OCW     = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1,
	localparam int AW      = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE * MAX_OUT_SIZE) : 1,
	localparam int PRW     = 2 * PIXEL_BITS,
	localparam int NTAP    = MAX_KERNEL * MAX_KERNEL
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                acc,
	input  logic                                cmd,
	input  logic [cacr_pkg::WPOS_BITS-1:0]      wrow,
	input  logic [cacr_pkg::WPOS_BITS-1:0]      wcol,
	input  logic [PIXEL_BITS-1:0]               px,
	input  logic                                first,
	input  logic                                last,
	input  logic [PW-1:0]                       row,
	input  logic [PW-1:0]                       col,
	input  logic [SW-1:0]                       base,
	input  logic [KW-1:0]                       k,
	input  logic [OSW-1:0]                      osz,
	output logic                                clr_busy,
	output cacr_pkg::ctl_t                      ctl_s2,
	output logic [AW-1:0]                       idx_s2,
	output logic [OCW-1:0]                      orow_s2,
	output logic [OCW-1:0]                      ocol_s2,
	output logic                                olast_s2,
	output logic [NTAP-1:0][PRW-1:0]            prod_s2
);

	// stage 1 registers
	logic                           v_s1;
	logic                           cmd_s1;
	logic [cacr_pkg::WPOS_BITS-1:0] wrow_s1;
	logic [cacr_pkg::WPOS_BITS-1:0] wcol_s1;
	logic signed [PIXEL_BITS-1:0]   px_s1;
	logic                           first_s1;
	logic                           last_s1;
	logic [PW-1:0]                  row_s1;
	logic [PW-1:0]                  col_s1;
	logic [SW-1:0]                  base_s1;

	logic signed [PIXEL_BITS-1:0] win_q [MAX_KERNEL][MAX_KERNEL];
	logic signed [PIXEL_BITS-1:0] win_nx [MAX_KERNEL][MAX_KERNEL];
	logic signed [PIXEL_BITS-1:0] w_q [MAX_KERNEL][MAX_KERNEL];
	logic signed [PIXEL_BITS-1:0] newcol [MAX_KERNEL];
	logic [NTAP-1:0][PRW-1:0]     prod_nx;

	logic [LINES*PIXEL_BITS-1:0] line_rdata;
	logic [LINES*PIXEL_BITS-1:0] line_mdata;
	logic [LINES*PIXEL_BITS-1:0] line_wdata;
	logic [PW-1:0]               line_waddr;
	logic                        line_we;
	logic                        pix_s1;

	logic          clr_q;
	logic [PW-1:0] clr_cnt_q;

	logic           win_ok;
	logic [OCW-1:0] orow;
	logic [OCW-1:0] ocol;
	logic [AW-1:0]  idx;
	logic           olast;

	assign pix_s1   = v_s1 && (cmd_s1 == cacr_pkg::CMD_PIXEL);
	assign clr_busy = clr_q;

	// line store clearing pass after reset, one column word per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + PW'(1);
			if (clr_cnt_q == PW'(ROW_LEN - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1   <= cmd;
			wrow_s1  <= wrow;
			wcol_s1  <= wcol;
			px_s1    <= px;
			first_s1 <= first;
			last_s1  <= last;
			row_s1   <= row;
			col_s1   <= col;
			base_s1  <= base;
		end
	end

	cacr_ram #(
		.WIDTH (LINES * PIXEL_BITS),
		.DEPTH (ROW_LEN)
	) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (line_waddr),
		.wdata (line_wdata),
		.re    (acc),
		.raddr (col),
		.rdata (line_rdata)
	);

	assign line_we    = clr_q || (en && pix_s1 && (k > KW'(1)));
	assign line_waddr = clr_q ? clr_cnt_q : col_s1;
	assign line_wdata = clr_q ? '0 : line_mdata;

	// new window column and line store update
	always_comb begin
		int            kk;
		logic [SW:0]   sidx;
		logic [SW-1:0] slot;
		kk         = int'(k);
		line_mdata = line_rdata;
		line_mdata[base_s1*PIXEL_BITS +: PIXEL_BITS] = px_s1;
		for (int r = 0; r < MAX_KERNEL; r++) begin
			sidx = (SW+1)'(base_s1) + (SW+1)'(r);
			if (int'(sidx) >= kk - 1) begin
				sidx = sidx - (SW+1)'(kk - 1);
			end
			slot = SW'(sidx);
			if (r == kk - 1) begin
				newcol[r] = px_s1;
			end else begin
				newcol[r] = line_rdata[slot*PIXEL_BITS +: PIXEL_BITS];
			end
		end
		for (int r = 0; r < MAX_KERNEL; r++) begin
			for (int c = 0; c < MAX_KERNEL; c++) begin
				win_nx[r][c] = win_q[r][c];
				if (r < kk) begin
					if (c + 1 < kk) begin
						win_nx[r][c] = win_q[r][c+1];
					end else if (c == kk - 1) begin
						win_nx[r][c] = newcol[r];
					end
				end
			end
		end
		for (int r = 0; r < MAX_KERNEL; r++) begin
			for (int c = 0; c < MAX_KERNEL; c++) begin
				if (r < kk && c < kk) begin
					prod_nx[r*MAX_KERNEL+c] = PRW'(win_nx[r][c]) * PRW'(w_q[r][c]);
				end else begin
					prod_nx[r*MAX_KERNEL+c] = '0;
				end
			end
		end
	end

	always_comb begin
		int kk;
		kk     = int'(k);
		win_ok = (int'(row_s1) >= kk - 1) && (int'(col_s1) >= kk - 1);
		orow   = OCW'(row_s1 - PW'(kk - 1));
		ocol   = OCW'(col_s1 - PW'(kk - 1));
		idx    = AW'(AW'(orow) * AW'(MAX_OUT_SIZE) + AW'(ocol));
		olast  = (orow == OCW'(osz - OSW'(1))) && (ocol == OCW'(osz - OSW'(1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_KERNEL; r++) begin
				for (int c = 0; c < MAX_KERNEL; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (en && pix_s1) begin
			win_q <= win_nx;
		end
	end

	// weights outside the largest kernel are dropped
	always_ff @(posedge clk) begin
		if (en && v_s1 && (cmd_s1 == cacr_pkg::CMD_WEIGHT)) begin
			for (int r = 0; r < MAX_KERNEL; r++) begin
				for (int c = 0; c < MAX_KERNEL; c++) begin
					if (wrow_s1 == cacr_pkg::WPOS_BITS'(r) &&
					    wcol_s1 == cacr_pkg::WPOS_BITS'(c)) begin
						w_q[r][c] <= px_s1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.vld   <= pix_s1 && win_ok;
			ctl_s2.first <= first_s1;
			ctl_s2.last  <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2   <= idx;
			orow_s2  <= orow;
			ocol_s2  <= ocol;
			olast_s2 <= olast;
			prod_s2  <= prod_nx;
		end
	end

endmodule

[hw/rtl/cacr_accum.sv]
// cacr_accum: window sum tree, partial sum read-modify-write and relu clamp
// depends on cacr_pkg and cacr_ram
module cacr_accum #(
	parameter int MAX_OUT_SIZE = 64,
	parameter int MAX_KERNEL   = 5,
	parameter int PIXEL_BITS   = 16,
	parameter int ACC_BITS     = 48,
	localparam int OCW  = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1,
	localparam int AW   = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE * MAX_OUT_SIZE) : 1,
	localparam int PRW  = 2 * PIXEL_BITS,
	localparam int NTAP = MAX_KERNEL * MAX_KERNEL
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  cacr_pkg::ctl_t                       ctl_s2,
	input  logic [AW-1:0]                        idx_s2,
	input  logic [OCW-1:0]                       orow_s2,
	input  logic [OCW-1:0]                       ocol_s2,
	input  logic                                 olast_s2,
	input  logic [NTAP-1:0][PRW-1:0]             prod_s2,
	output logic                                 res_vld,
	output logic [cacr_pkg::OUT_VALUE_BITS-1:0]  res_value,
	output logic [OCW-1:0]                       res_row,
	output logic [OCW-1:0]                       res_col,
	output logic                                 res_last
);

	localparam int RSW = PRW + 3;
	localparam int TW  = PRW + 6;
	localparam int CW  = ((TW > ACC_BITS) ? TW : ACC_BITS) + 1;
	localparam logic signed [CW-1:0] ACC_MAX_X = (CW'(1) <<< (ACC_BITS - 1)) - CW'(1);
	localparam logic signed [CW-1:0] ACC_MIN_X = -ACC_MAX_X - CW'(1);
	localparam logic signed [CW-1:0] OUT_MAX_X = CW'(cacr_pkg::OUT_VALUE_MAX);

	cacr_pkg::ctl_t              ctl_s3;
	logic [AW-1:0]               idx_s3;
	logic [OCW-1:0]              orow_s3;
	logic [OCW-1:0]              ocol_s3;
	logic                        olast_s3;
	logic signed [RSW-1:0]       rsum_s3 [MAX_KERNEL];
	logic signed [RSW-1:0]       rsum_nx [MAX_KERNEL];
	logic                        fwd_s3;
	logic signed [ACC_BITS-1:0]  wdat_q;
	logic signed [ACC_BITS-1:0]  ps_rdata;
	logic signed [ACC_BITS-1:0]  old_sum;
	logic signed [ACC_BITS-1:0]  win_sum;
	logic signed [ACC_BITS-1:0]  new_sum;

	// row sums of the window products
	always_comb begin
		for (int r = 0; r < MAX_KERNEL; r++) begin
			rsum_nx[r] = '0;
			for (int c = 0; c < MAX_KERNEL; c++) begin
				rsum_nx[r] = rsum_nx[r] + RSW'(signed'(prod_s2[r*MAX_KERNEL+c]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			fwd_s3 <= 1'b0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
			// the entry written this cycle is missed by the read issued this cycle
			fwd_s3 <= ctl_s3.vld && ctl_s2.vld && (idx_s3 == idx_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s3   <= idx_s2;
			orow_s3  <= orow_s2;
			ocol_s3  <= ocol_s2;
			olast_s3 <= olast_s2;
			rsum_s3  <= rsum_nx;
			wdat_q   <= new_sum;
		end
	end

	cacr_ram #(
		.WIDTH (ACC_BITS),
		.DEPTH (MAX_OUT_SIZE * MAX_OUT_SIZE)
	) u_psum_ram (
		.clk   (clk),
		.we    (en && ctl_s3.vld),
		.waddr (idx_s3),
		.wdata (new_sum),
		.re    (en),
		.raddr (idx_s2),
		.rdata (ps_rdata)
	);

	assign old_sum = fwd_s3 ? wdat_q : ps_rdata;

	always_comb begin
		logic signed [CW-1:0] tot;
		logic signed [CW-1:0] acc_x;
		tot = '0;
		for (int r = 0; r < MAX_KERNEL; r++) begin
			tot = tot + CW'(rsum_s3[r]);
		end
		if (tot > ACC_MAX_X) begin
			win_sum = ACC_BITS'(ACC_MAX_X);
		end else if (tot < ACC_MIN_X) begin
			win_sum = ACC_BITS'(ACC_MIN_X);
		end else begin
			win_sum = ACC_BITS'(tot);
		end
		acc_x = CW'(old_sum) + CW'(win_sum);
		if (ctl_s3.first) begin
			new_sum = win_sum;
		end else if (acc_x > ACC_MAX_X) begin
			new_sum = ACC_BITS'(ACC_MAX_X);
		end else if (acc_x < ACC_MIN_X) begin
			new_sum = ACC_BITS'(ACC_MIN_X);
		end else begin
			new_sum = ACC_BITS'(acc_x);
		end
	end

	// relu and clamp to the pixel range
	always_comb begin
		logic signed [CW-1:0] nx;
		nx = CW'(new_sum);
		if (nx < CW'(0)) begin
			res_value = '0;
		end else if (nx > OUT_MAX_X) begin
			res_value = cacr_pkg::OUT_VALUE_MAX;
		end else begin
			res_value = cacr_pkg::OUT_VALUE_BITS'(nx);
		end
	end

	assign res_vld  = ctl_s3.vld && ctl_s3.last;
	assign res_row  = orow_s3;
	assign res_col  = ocol_s3;
	assign res_last = olast_s3;

endmodule

[hw/rtl/conv2d_channel_accumulate_relu_core.sv]
// conv2d_channel_accumulate_relu_core: top level, config registers, raster position
// and result skid buffer; depends on cacr_pkg, cacr_window, cacr_accum
//
// channel   handshake              payload
// input     valid / stall          command weight_row weight_col value plane_first plane_last
// result    out_valid / out_stall  out_value out_row out_col out_last
// config    cfg_valid / cfg_ready  cfg_index cfg_data
//
// one item per cycle while stall is low; a pixel's result leaves from the output register
// after stage 1 line ram read and window, stage 2 sum tree, stage 3 partial sum ram
// after reset the line store is cleared, one column per cycle, all MAX_OUT_SIZE +
// MAX_KERNEL - 1 columns with stall held high; config writes are taken at once
// a full result skid buffer freezes the pipeline and raises stall
module conv2d_channel_accumulate_relu_core #(
	parameter int MAX_OUT_SIZE = 64,
	parameter int MAX_KERNEL   = 5,
	parameter int PIXEL_BITS   = 16,
	parameter int ACC_BITS     = 48,
	localparam int OCW = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 valid,
	output logic                                 stall,
	input  logic                                 command,
	input  logic [cacr_pkg::WPOS_BITS-1:0]       weight_row,
	input  logic [cacr_pkg::WPOS_BITS-1:0]       weight_col,
	input  logic [PIXEL_BITS-1:0]                value,
	input  logic                                 plane_first,
	input  logic                                 plane_last,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [cacr_pkg::OUT_VALUE_BITS-1:0]  out_value,
	output logic [OCW-1:0]                       out_row,
	output logic [OCW-1:0]                       out_col,
	output logic                                 out_last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cacr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [cacr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int ROW_LEN = MAX_OUT_SIZE + MAX_KERNEL - 1;
	localparam int LINES   = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
	localparam int PW      = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
	localparam int SDW     = $clog2(ROW_LEN + 1);
	localparam int SW      = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int KW      = $clog2(MAX_KERNEL + 1);
	localparam int OSW     = $clog2(MAX_OUT_SIZE + 1);
	localparam int AW      = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE * MAX_OUT_SIZE) : 1;
	localparam int PRW     = 2 * PIXEL_BITS;
	localparam int NTAP    = MAX_KERNEL * MAX_KERNEL;
	localparam int OSZ_RST = (MAX_OUT_SIZE < 8) ? MAX_OUT_SIZE : 8;

	logic [KW-1:0]  k_q;
	logic [OSW-1:0] osz_q;
	logic [PW-1:0]  row_q;
	logic [PW-1:0]  col_q;
	logic [SW-1:0]  base_q;
	logic [SDW-1:0] side;
	logic           in_xfer;
	logic           cfg_xfer;
	logic           en;
	logic           clr_busy;
	logic           skid_full_q;

	logic [cacr_pkg::KSIZE_BITS-1:0] ks_raw;
	logic [cacr_pkg::OSIZE_BITS-1:0] os_raw;

	cacr_pkg::ctl_t           ctl_s2;
	logic [AW-1:0]            idx_s2;
	logic [OCW-1:0]           orow_s2;
	logic [OCW-1:0]           ocol_s2;
	logic                     olast_s2;
	logic [NTAP-1:0][PRW-1:0] prod_s2;

	logic                                res_vld;
	logic [cacr_pkg::OUT_VALUE_BITS-1:0] res_value;
	logic [OCW-1:0]                      res_row;
	logic [OCW-1:0]                      res_col;
	logic                                res_last;

	logic [cacr_pkg::OUT_VALUE_BITS-1:0] sk_value_q;
	logic [OCW-1:0]                      sk_row_q;
	logic [OCW-1:0]                      sk_col_q;
	logic                                sk_last_q;

	assign en        = !skid_full_q;
	assign stall     = skid_full_q || clr_busy;
	assign in_xfer   = valid && !stall;
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign side      = SDW'(osz_q) + SDW'(k_q) - SDW'(1);
	assign ks_raw    = cfg_data[cacr_pkg::KSIZE_BITS-1:0];
	assign os_raw    = cfg_data[cacr_pkg::OSIZE_BITS-1:0];

	// registers hold the clamped sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= KW'(1);
			osz_q <= OSW'(OSZ_RST);
		end else if (cfg_xfer) begin
			case (cfg_index)
				cacr_pkg::REG_KERNEL_SIZE: begin
					if (ks_raw == '0) begin
						k_q <= KW'(1);
					end else if (int'(ks_raw) > MAX_KERNEL) begin
						k_q <= KW'(MAX_KERNEL);
					end else begin
						k_q <= KW'(ks_raw);
					end
				end
				cacr_pkg::REG_OUT_SIZE: begin
					if (os_raw == '0) begin
						osz_q <= OSW'(1);
					end else if (int'(os_raw) > MAX_OUT_SIZE) begin
						osz_q <= OSW'(MAX_OUT_SIZE);
					end else begin
						osz_q <= OSW'(os_raw);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// raster position of the next pixel and the line slot of its row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			base_q <= '0;
		end else if (cfg_xfer) begin
			row_q  <= '0;
			col_q  <= '0;
			base_q <= '0;
		end else if (in_xfer && command == cacr_pkg::CMD_PIXEL) begin
			if (SDW'(col_q) + SDW'(1) >= side) begin
				col_q <= '0;
				if (SDW'(row_q) + SDW'(1) >= side) begin
					row_q  <= '0;
					base_q <= '0;
				end else begin
					row_q <= row_q + PW'(1);
					if (int'(base_q) + 2 >= int'(k_q)) begin
						base_q <= '0;
					end else begin
						base_q <= base_q + SW'(1);
					end
				end
			end else begin
				col_q <= col_q + PW'(1);
			end
		end
	end

	cacr_window #(
		.MAX_OUT_SIZE (MAX_OUT_SIZE),
		.MAX_KERNEL   (MAX_KERNEL),
		.PIXEL_BITS   (PIXEL_BITS)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.acc      (in_xfer),
		.cmd      (command),
		.wrow     (weight_row),
		.wcol     (weight_col),
		.px       (value),
		.first    (plane_first),
		.last     (plane_last),
		.row      (row_q),
		.col      (col_q),
		.base     (base_q),
		.k        (k_q),
		.osz      (osz_q),
		.clr_busy (clr_busy),
		.ctl_s2   (ctl_s2),
		.idx_s2   (idx_s2),
		.orow_s2  (orow_s2),
		.ocol_s2  (ocol_s2),
		.olast_s2 (olast_s2),
		.prod_s2  (prod_s2)
	);

	cacr_accum #(
		.MAX_OUT_SIZE (MAX_OUT_SIZE),
		.MAX_KERNEL   (MAX_KERNEL),
		.PIXEL_BITS   (PIXEL_BITS),
		.ACC_BITS     (ACC_BITS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_s2    (ctl_s2),
		.idx_s2    (idx_s2),
		.orow_s2   (orow_s2),
		.ocol_s2   (ocol_s2),
		.olast_s2  (olast_s2),
		.prod_s2   (prod_s2),
		.res_vld   (res_vld),
		.res_value (res_value),
		.res_row   (res_row),
		.res_col   (res_col),
		.res_last  (res_last)
	);

	// output register plus one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid   <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			if (skid_full_q) begin
				out_valid   <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_valid <= res_vld;
			end
		end else if (res_vld && en) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid || !out_stall) begin
			if (skid_full_q) begin
				out_value <= sk_value_q;
				out_row   <= sk_row_q;
				out_col   <= sk_col_q;
				out_last  <= sk_last_q;
			end else begin
				out_value <= res_value;
				out_row   <= res_row;
				out_col   <= res_col;
				out_last  <= res_last;
			end
		end else if (res_vld && en) begin
			sk_value_q <= res_value;
			sk_row_q   <= res_row;
			sk_col_q   <= res_col;
			sk_last_q  <= res_last;
		end
	end

endmodule

[hw/rtl/cacr_chk.sv]
// cacr_chk: port level checker for the conv2d channel accumulate core, with its bind
// depends on cacr_pkg and the top level port list
module cacr_chk #(
	parameter int MAX_OUT_SIZE = 64,
	parameter int PIXEL_BITS   = 16,
	localparam int OCW = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 valid,
	input logic                                 stall,
	input logic                                 command,
	input logic [PIXEL_BITS-1:0]                value,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic [cacr_pkg::OUT_VALUE_BITS-1:0]  out_value,
	input logic [OCW-1:0]                       out_row,
	input logic [OCW-1:0]                       out_col,
	input logic                                 out_last,
	input logic                                 cfg_valid,
	input logic                                 cfg_ready
);

	// the final position of a square plane sits on the diagonal
	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_row == out_col)
		else $error("last result off the diagonal");

	// config writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

	// no result comes out too soon after reset
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(out_valid, 1) && $past(arst_n, 3))
		else $error("result too soon after reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_row)
			&& $stable(out_col) && $stable(out_last))
		else $error("stalled result changed");

	// a stalled input transfer keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && stall |=> valid && $stable(command) && $stable(value))
		else $error("stalled input changed");

endmodule

bind conv2d_channel_accumulate_relu_core cacr_chk #(
	.MAX_OUT_SIZE (MAX_OUT_SIZE),
	.PIXEL_BITS   (PIXEL_BITS)
) u_cacr_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.valid     (valid),
	.stall     (stall),
	.command   (command),
	.value     (value),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_value (out_value),
	.out_row   (out_row),
	.out_col   (out_col),
	.out_last  (out_last),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

[bench/conv2d_channel_accumulate_relu_core_tb.sv]
// testbench for conv2d_channel_accumulate_relu_core: weight loads and pixel planes
// checked against a behavioral convolution and partial-sum model; depends on cacr_pkg
module conv2d_channel_accumulate_relu_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cacr_pkg::*;

	localparam int MAXO = 64;
	localparam int MAXK = 5;
	localparam int ROWW = MAXO + MAXK - 1;
	localparam longint SUM_MAX = (longint'(1) <<< 47) - 1;
	localparam longint SUM_MIN = -SUM_MAX - 1;
	localparam int CYCLE_LIMIT = 900000;
	localparam int ITEM_GOAL = 1850;

	typedef enum {VAL_RANDOM, VAL_MAX, VAL_MIN} val_mode_t;

	typedef struct packed {
		logic [OUT_VALUE_BITS-1:0] v;
		logic [5:0] r;
		logic [5:0] c;
		logic l;
	} conv_result_t;

	logic clk, arst_n;
	logic valid, stall, command, plane_first, plane_last;
	logic [WPOS_BITS-1:0] weight_row, weight_col;
	logic [15:0] value;
	logic out_valid, out_stall, out_last;
	logic [OUT_VALUE_BITS-1:0] out_value;
	logic [5:0] out_row, out_col;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	conv2d_channel_accumulate_relu_core dut (.*);

	// predictor state
	logic [2:0] ks_reg;
	logic [6:0] os_reg;
	longint kern[25];
	longint line_mem[(MAXK-1)*ROWW];
	longint win[25];
	longint psum[MAXO*MAXO];
	bit psum_valid[MAXO*MAXO];
	int prow, pcol;

	conv_result_t pending_results[$];
	int errors = 0;
	int pixels_sent = 0;
	int cycles = 0;
	bit no_idle = 0;
	bit hold_req = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** conv2d_channel_accumulate_relu_core: FAILED **");
			$finish;
		end
	end

	function automatic int kact();
		return (ks_reg < 1) ? 1 : (ks_reg > MAXK) ? MAXK : ks_reg;
	endfunction

	function automatic int oact();
		return (os_reg < 1) ? 1 : (os_reg > MAXO) ? MAXO : os_reg;
	endfunction

	function automatic longint sat_add(longint a, longint b);
		if (b > 0 && a > SUM_MAX - b) return SUM_MAX;
		if (b < 0 && a < SUM_MIN - b) return SUM_MIN;
		return a + b;
	endfunction

	// advances the pixel model; first may be forced so no unwritten sum is read
	function automatic bit model_pixel(input logic [15:0] raw, inout bit first, input bit last,
			output conv_result_t res);
		int k, osz, side, orow, ocol, idx;
		longint px, sum, v;
		bit produced;
		k = kact();
		osz = oact();
		side = osz + k - 1;
		px = longint'($signed(raw));
		produced = 0;
		res = '0;
		for (int r = 0; r < k; r++) begin
			for (int c = 0; c + 1 < k; c++)
				win[r*MAXK+c] = win[r*MAXK+c+1];
			if (r + 1 < k)
				win[r*MAXK+k-1] = line_mem[((prow + r) % (k - 1))*ROWW + pcol];
			else
				win[r*MAXK+k-1] = px;
		end
		if (k > 1)
			line_mem[(prow % (k - 1))*ROWW + pcol] = px;
		if (prow >= k - 1 && pcol >= k - 1) begin
			orow = prow - (k - 1);
			ocol = pcol - (k - 1);
			idx = orow*MAXO + ocol;
			sum = 0;
			for (int r = 0; r < k; r++)
				for (int c = 0; c < k; c++)
					sum = sat_add(sum, win[r*MAXK+c] * kern[r*MAXK+c]);
			if (!psum_valid[idx])
				first = 1;
			psum[idx] = first ? sum : sat_add(psum[idx], sum);
			psum_valid[idx] = 1;
			if (last) begin
				v = psum[idx];
				if (v < 0) v = 0;
				if (v > 32767) v = 32767;
				res.v = v[14:0];
				res.r = orow[5:0];
				res.c = ocol[5:0];
				res.l = (orow == osz - 1 && ocol == osz - 1);
				produced = 1;
			end
		end
		pcol++;
		if (pcol >= side) begin
			pcol = 0;
			prow++;
			if (prow >= side) prow = 0;
		end
		return produced;
	endfunction

	// one input transfer; valid stays high across back-to-back items
	task automatic send_item(logic cmd, logic [2:0] wr, logic [2:0] wc, logic [15:0] val,
			bit first, bit last);
		int gap;
		conv_result_t res;
		gap = no_idle ? 0 : int'($urandom_range(0, 7));
		if (cmd == CMD_WEIGHT) begin
			if (wr < MAXK && wc < MAXK)
				kern[wr*MAXK+wc] = longint'($signed(val));
		end else begin
			if (model_pixel(val, first, last, res))
				pending_results.push_back(res);
			pixels_sent++;
		end
		if (gap > 0) begin
			valid = 0;
			repeat (gap) @(negedge clk);
		end
		command = cmd;
		weight_row = wr;
		weight_col = wc;
		value = val;
		plane_first = first;
		plane_last = last;
		valid = 1;
		do @(posedge clk); while (stall);
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_value(val_mode_t mode);
		case (mode)
			VAL_MAX: return 16'h7fff;
			VAL_MIN: return 16'h8000;
			default: begin
				case ($urandom_range(0, 3))
					0: return 16'($urandom());
					1: return 16'h7ff0 | 16'($urandom_range(0, 15));
					2: return 16'h8000 | 16'($urandom_range(0, 15));
					default: return 16'(int'($urandom_range(0, 200)) - 100);
				endcase
			end
		endcase
	endfunction

	task automatic load_kernel(val_mode_t mode);
		for (int r = 0; r < MAXK; r++)
			for (int c = 0; c < MAXK; c++)
				send_item(CMD_WEIGHT, 3'(r), 3'(c), pick_value(mode), 1'($urandom()),
					1'($urandom()));
	endtask

	// pixels with random marks mixed in on weight transfers, some outside the kernel
	task automatic stream_pixels(int n, bit first, bit last, val_mode_t mode, bit mix);
		for (int i = 0; i < n; i++) begin
			if (mix && $urandom_range(0, 39) == 0)
				send_item(CMD_WEIGHT, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
					pick_value(VAL_RANDOM), 1'($urandom()), 1'($urandom()));
			send_item(CMD_PIXEL, 3'($urandom()), 3'($urandom()), pick_value(mode), first, last);
		end
	endtask

	task automatic drain();
		valid = 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
		if (idx == REG_KERNEL_SIZE)
			ks_reg = data[2:0];
		else
			os_reg = data;
		prow = 0;
		pcol = 0;
	endtask

	task automatic run_layer(int channels, val_mode_t mode, bit mix);
		int side;
		side = oact() + kact() - 1;
		for (int ch = 0; ch < channels; ch++) begin
			if ($urandom_range(0, 1))
				load_kernel(VAL_RANDOM);
			stream_pixels(side*side, ch == 0, ch == channels - 1, mode, mix);
		end
	endtask

	// saturation high and low, ignored weight positions
	task automatic test_directed_extremes();
		write_reg(REG_KERNEL_SIZE, 7'd3);
		write_reg(REG_OUT_SIZE, 7'd1);
		load_kernel(VAL_MAX);
		stream_pixels(9, 1'b1, 1'b1, VAL_MAX, 1'b0);
		stream_pixels(9, 1'b1, 1'b1, VAL_MIN, 1'b0);
		send_item(CMD_WEIGHT, 3'd5, 3'd7, 16'h1234, 1'b1, 1'b1);
		send_item(CMD_WEIGHT, 3'd7, 3'd0, 16'h5555, 1'b0, 1'b0);
		stream_pixels(9, 1'b1, 1'b1, VAL_RANDOM, 1'b0);
		drain();
	endtask

	// out of range register values clamp; a write mid-plane restarts the raster
	task automatic test_register_extremes();
		write_reg(REG_KERNEL_SIZE, 7'd0);
		write_reg(REG_OUT_SIZE, 7'd0);
		stream_pixels(4, 1'b1, 1'b1, VAL_RANDOM, 1'b0);
		drain();
		write_reg(REG_KERNEL_SIZE, 7'h7f);
		write_reg(REG_OUT_SIZE, 7'h7f);
		stream_pixels(6*ROWW, 1'b1, 1'b1, VAL_RANDOM, 1'b0);
		drain();
		write_reg(REG_KERNEL_SIZE, 7'd5);
		write_reg(REG_OUT_SIZE, 7'd64);
		stream_pixels(5*ROWW + 3, 1'b1, 1'b1, VAL_RANDOM, 1'b0);
		drain();
		write_reg(REG_OUT_SIZE, 7'd3);
		run_layer(3, VAL_RANDOM, 1'b1);
		drain();
	endtask

	// receiver holds off while planes keep coming, so the core stalls its input
	task automatic test_backpressure();
		write_reg(REG_KERNEL_SIZE, 7'd2);
		write_reg(REG_OUT_SIZE, 7'd8);
		no_idle = 1;
		hold_req = 1;
		run_layer(2, VAL_RANDOM, 1'b0);
		no_idle = 0;
		drain();
	endtask

	task automatic test_random_layers();
		while (pixels_sent < ITEM_GOAL) begin
			write_reg(REG_KERNEL_SIZE, 7'($urandom_range(1, 5)));
			write_reg(REG_OUT_SIZE, $urandom_range(0, 9) == 0 ? 7'($urandom_range(9, 16))
				: 7'($urandom_range(1, 6)));
			no_idle = ($urandom_range(0, 3) == 0);
			run_layer(int'($urandom_range(1, 3)), VAL_RANDOM, 1'b1);
			drain();
		end
		no_idle = 0;
	endtask

	// result side: random stall per transfer, one long hold-off on request
	initial begin
		int n;
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1;
				repeat (300) @(negedge clk);
				hold_req = 0;
			end
			n = no_idle ? 0 : int'($urandom_range(0, 7));
			if (n > 0) begin
				out_stall = 1;
				repeat (n) @(negedge clk);
			end
			out_stall = 0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		conv_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result value %0d row %0d col %0d", $time,
					out_value, out_row, out_col);
			end else begin
				want = pending_results.pop_front();
				if (out_value !== want.v) begin
					errors++;
					$display("%0t: out_value expected %0d actual %0d", $time, want.v, out_value);
				end
				if (out_row !== want.r) begin
					errors++;
					$display("%0t: out_row expected %0d actual %0d", $time, want.r, out_row);
				end
				if (out_col !== want.c) begin
					errors++;
					$display("%0t: out_col expected %0d actual %0d", $time, want.c, out_col);
				end
				if (out_last !== want.l) begin
					errors++;
					$display("%0t: out_last expected %0d actual %0d", $time, want.l, out_last);
				end
			end
		end
	end

	initial begin
		arst_n = 0;
		valid = 0;
		command = CMD_PIXEL;
		weight_row = '0;
		weight_col = '0;
		value = '0;
		plane_first = 0;
		plane_last = 0;
		cfg_valid = 0;
		cfg_index = REG_KERNEL_SIZE;
		cfg_data = '0;
		ks_reg = 3'd1;
		os_reg = 7'd8;
		prow = 0;
		pcol = 0;
		foreach (line_mem[i]) line_mem[i] = 0;
		foreach (win[i]) win[i] = 0;
		foreach (kern[i]) kern[i] = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;
		// every weight written before the first pixel
		load_kernel(VAL_RANDOM);
		stream_pixels(64, 1'b1, 1'b1, VAL_RANDOM, 1'b0);
		drain();
		test_directed_extremes();
		test_register_extremes();
		test_backpressure();
		test_random_layers();
		drain();
		if (errors == 0)
			$display("** conv2d_channel_accumulate_relu_core: PASSED **");
		else
			$display("** conv2d_channel_accumulate_relu_core: FAILED **");
		$finish;
	end
endmodule

[sim.f]
hw/rtl/cacr_pkg.sv
hw/rtl/cacr_ram.sv
hw/rtl/cacr_window.sv
hw/rtl/cacr_accum.sv
hw/rtl/conv2d_channel_accumulate_relu_core.sv
hw/rtl/cacr_chk.sv
bench/conv2d_channel_accumulate_relu_core_tb.sv
